// ===== sv/ialu_pkg.sv =====
// Package for the pipelined integer ALU: opcodes and payload widths.
// No dependencies.
package ialu_pkg;
    localparam int unsigned OP_W = 4;
    localparam int unsigned OPND_W = 32;
    localparam int unsigned RES_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOD  = 4'd4,
        OP_NOTA = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_XOR  = 4'd8,
        OP_XNOR = 4'd9,
        OP_IMPL = 4'd10,
        OP_NAND = 4'd11,
        OP_NOR  = 4'd12
    } t_op;
endpackage

// ===== sv/ialu_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on ialu_pkg (none of its items needed beyond the import style).
module ialu_div
    import ialu_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);
    // stage k holds the partial remainder, remaining dividend bits, quotient
    logic [WIDTH-1:0] r_rem [WIDTH+1];
    logic [WIDTH-1:0] r_num [WIDTH];
    logic [WIDTH-1:0] r_quo [WIDTH+1];
    logic [WIDTH-1:0] r_den [WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_num;
            r_quo[0] <= '0;
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 0; k < WIDTH; k++) begin : g_stage
        logic [WIDTH:0] n_trial;
        logic [WIDTH:0] n_diff;
        assign n_trial = {r_rem[k], r_num[k][WIDTH-1]};
        assign n_diff  = n_trial - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_diff[WIDTH] ? n_trial[WIDTH-1:0] : n_diff[WIDTH-1:0];
                r_quo[k+1] <= {r_quo[k][WIDTH-2:0], ~n_diff[WIDTH]};
            end
        end
        // dividend bits and divisor move on only while a later stage needs them
        if (k < WIDTH - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k+1] <= {r_num[k][WIDTH-2:0], 1'b0};
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_quo = r_quo[WIDTH];
    assign o_rem = r_rem[WIDTH];
endmodule

// ===== sv/integer_alu_with_divide_top.sv =====
// Integer ALU: add, sub, full multiply, unsigned divide/modulo, logic ops.
// Registers in order: input register, divider input register, WIDTH divider stages,
// output register; throughput one transaction per cycle while the output is not held.
// The whole pipeline advances together, stalled only by a held output.
// Reset (i_rst_n, synchronous) clears the stage valid bits; data is not reset.
module integer_alu_with_divide_top
    import ialu_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,  // req_type[3:0], operand_a[35:4], operand_b[67:36]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,  // result_value[63:0]
    output logic          m_axis_tuser   // divide_by_zero
);
    localparam int unsigned DEPTH = WIDTH + 1;

    logic n_en;
    logic r_vld [DEPTH+1];
    assign n_en = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = n_en;

    // stage 0: capture opcode and operands
    logic [OP_W-1:0]  r_op0;
    logic [WIDTH-1:0] r_a0, r_b0;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_op0 <= s_axis_tdata[3:0];
            r_a0  <= s_axis_tdata[4 +: WIDTH];
            r_b0  <= s_axis_tdata[36 +: WIDTH];
        end
    end

    // divider stages
    logic [WIDTH-1:0] w_quo, w_rem;
    ialu_div #(.WIDTH(WIDTH)) u_div (
        .i_clk(i_clk), .i_en(n_en), .i_num(r_a0), .i_den(r_b0),
        .o_quo(w_quo), .o_rem(w_rem)
    );

    // first stage computes non-divide result; it rides along the delay line
    logic [OP_W-1:0]    r_op  [1:DEPTH];
    logic [2*WIDTH-1:0] r_res [1:DEPTH];
    logic               r_bz  [1:DEPTH];
    logic [2*WIDTH-1:0] n_res;
    always_comb begin
        n_res = '0;
        case (t_op'(r_op0))
            OP_ADD:  n_res[WIDTH-1:0] = r_a0 + r_b0;
            OP_SUB:  n_res[WIDTH-1:0] = r_a0 - r_b0;
            OP_MUL:  n_res = (2*WIDTH)'(r_a0) * (2*WIDTH)'(r_b0);
            OP_NOTA: n_res[WIDTH-1:0] = ~r_a0;
            OP_AND:  n_res[WIDTH-1:0] = r_a0 & r_b0;
            OP_OR:   n_res[WIDTH-1:0] = r_a0 | r_b0;
            OP_XOR:  n_res[WIDTH-1:0] = r_a0 ^ r_b0;
            OP_XNOR: n_res[WIDTH-1:0] = ~(r_a0 ^ r_b0);
            OP_IMPL: n_res[WIDTH-1:0] = ~r_a0 | r_b0;
            OP_NAND: n_res[WIDTH-1:0] = ~(r_a0 & r_b0);
            OP_NOR:  n_res[WIDTH-1:0] = ~(r_a0 | r_b0);
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_res[1] <= n_res;
            r_bz[1]  <= (r_b0 == '0);
            r_op[1]  <= r_op0;
            for (int k = 2; k <= DEPTH; k++) begin
                r_res[k] <= r_res[k-1];
                r_bz[k]  <= r_bz[k-1];
                r_op[k]  <= r_op[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (n_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k <= DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // output register: merge divider result
    logic [63:0] r_out;
    logic        r_dz, r_ov;
    logic        n_isdiv, n_ismod;
    assign n_isdiv = (t_op'(r_op[DEPTH]) == OP_DIV);
    assign n_ismod = (t_op'(r_op[DEPTH]) == OP_MOD);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (n_en) begin
            r_ov <= r_vld[DEPTH];
        end
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out <= '0;
            r_dz  <= 1'b0;
            if ((n_isdiv || n_ismod) && r_bz[DEPTH]) begin
                r_dz <= 1'b1;
            end else if (n_isdiv) begin
                r_out[WIDTH-1:0] <= w_quo;
            end else if (n_ismod) begin
                r_out[WIDTH-1:0] <= w_rem;
            end else begin
                r_out[2*WIDTH-1:0] <= r_res[DEPTH];
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_dz;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed during stall");
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("divide by zero with nonzero result");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline stalled with empty output");
endmodule

// ===== tb/tb_integer_alu_with_divide_top.sv =====
// Testbench for integer_alu_with_divide_top: directed and random ALU transactions
// checked against an in-bench predictor. Depends on ialu_pkg and the top module.
module tb_integer_alu_with_divide_top;
    import ialu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WIDTH = 32;
    localparam int unsigned LATENCY = WIDTH + 3;
    localparam longint unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        dz;
        logic [63:0] value;
    } t_alu_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    t_alu_res        pending_results[$];
    int unsigned     mismatch_cnt;
    longint unsigned cycle_cnt;
    bit              stall_enable;
    int              out_wait;

    integer_alu_with_divide_top #(.WIDTH(WIDTH)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Predict one ALU result
    function automatic t_alu_res alu_predict(logic [3:0] opc, logic [31:0] a, logic [31:0] b);
        t_alu_res r;
        r = '0;
        case (opc)
            OP_ADD:  r.value = {32'd0, a + b};
            OP_SUB:  r.value = {32'd0, a - b};
            OP_MUL:  r.value = {32'd0, a} * {32'd0, b};
            OP_DIV:  if (b == 0) r.dz = 1'b1; else r.value = {32'd0, a / b};
            OP_MOD:  if (b == 0) r.dz = 1'b1; else r.value = {32'd0, a % b};
            OP_NOTA: r.value = {32'd0, ~a};
            OP_AND:  r.value = {32'd0, a & b};
            OP_OR:   r.value = {32'd0, a | b};
            OP_XOR:  r.value = {32'd0, a ^ b};
            OP_XNOR: r.value = {32'd0, ~(a ^ b)};
            OP_IMPL: r.value = {32'd0, ~a | b};
            OP_NAND: r.value = {32'd0, ~(a & b)};
            OP_NOR:  r.value = {32'd0, ~(a | b)};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Send one transaction, after a random gap when stalls are enabled
    task automatic send_op(logic [3:0] opc, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = stall_enable ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, b, a, opc};
        pending_results.push_back(alu_predict(opc, a, b));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Output side: random wait after each accepted result when stalls are enabled, compare each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_wait      <= 0;
        end else begin
            int w;
            w = stall_enable ? $urandom_range(0, 5) : 0;
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result %h dz %b", m_axis_tdata, m_axis_tuser);
                end else begin
                    t_alu_res exp_res;
                    exp_res = pending_results.pop_front();
                    if (exp_res.value !== m_axis_tdata || exp_res.dz !== m_axis_tuser) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp %h dz %b, got %h dz %b", exp_res.value,
                                     exp_res.dz, m_axis_tdata, m_axis_tuser);
                    end
                end
                out_wait      <= w;
                m_axis_tready <= (w == 0);
            end else if (out_wait > 1) begin
                out_wait <= out_wait - 1;
            end else begin
                out_wait      <= 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Extremes of operands, every opcode, zero divisor, a below b, unused opcodes
    task automatic test_directed();
        send_op(OP_ADD, 32'hFFFF_FFFF, 32'd1);
        send_op(OP_SUB, 32'd0, 32'd1);
        send_op(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_DIV, 32'd1234, 32'd0);
        send_op(OP_MOD, 32'hFFFF_FFFF, 32'd0);
        send_op(OP_DIV, 32'd5, 32'd9);
        send_op(OP_MOD, 32'd5, 32'd9);
        send_op(OP_DIV, 32'hFFFF_FFFF, 32'd1);
        send_op(OP_MOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_NOTA, 32'd0, 32'hFFFF_FFFF);
        send_op(OP_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_op(OP_OR, 32'd0, 32'h8000_0001);
        send_op(OP_XOR, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
        send_op(OP_XNOR, 32'h1234_5678, 32'h1234_5678);
        send_op(OP_IMPL, 32'hFFFF_0000, 32'h00FF_00FF);
        send_op(OP_NAND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_NOR, 32'd0, 32'd0);
        send_op(4'd13, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(4'd14, 32'd7, 32'd3);
        send_op(4'd15, 32'hFFFF_FFFF, 32'd0);
    endtask

    // Random operations; divisors sometimes zero or small, operand a sometimes small, unused opcodes now and then
    task automatic test_random(int count);
        logic [3:0]  opc;
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++) begin
            opc = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                : 4'($urandom_range(0, 12));
            a = $urandom;
            b = $urandom;
            case ($urandom_range(0, 7))
                0: b = '0;
                1: b = 32'($urandom_range(1, 255));
                2: a = 32'($urandom_range(0, 255));
                default: ;
            endcase
            send_op(opc, a, b);
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_full_rate();
        stall_enable = 1'b0;
        test_random(150);
        stall_enable = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mismatch_cnt  = 0;
        cycle_cnt     = 0;
        stall_enable  = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        drain_results();
        test_random(500);
        test_full_rate();
        drain_results();
        test_random(430);
        drain_results();
        repeat (LATENCY + 5) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/ialu_pkg.sv
sv/ialu_div.sv
sv/integer_alu_with_divide_top.sv
tb/tb_integer_alu_with_divide_top.sv
